// ===== hw/rtl/iis_pkg.sv =====
`default_nettype none

package iis_pkg;

	localparam int MAX_INTERVALS_DEF = 16;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_QUERY  = 2'd2;
	localparam logic [1:0] FN_ADD    = 2'd3;

	localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic clear;
		logic feed;
		logic flush;
	} merge_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iis_ram.sv =====
`default_nettype none

module iis_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/iis_merge.sv =====
`default_nettype none

module iis_merge #(
	parameter int MAX_INTERVALS = iis_pkg::MAX_INTERVALS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire iis_pkg::merge_ctl_t                 ctl,
	input  wire logic signed [63:0]                  a,
	input  wire logic signed [63:0]                  b,
	output logic                                     we,
	output logic [$clog2(MAX_INTERVALS)-1:0]         widx,
	output logic signed [63:0]                       wlo,
	output logic signed [63:0]                       whi,
	output logic [$clog2(MAX_INTERVALS+1)-1:0]       count,
	output logic                                     full
);

	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int IW = $clog2(MAX_INTERVALS);

	logic                 cur_valid_q;
	logic signed [63:0]   cur_lo_q;
	logic signed [63:0]   cur_hi_q;
	logic [CW-1:0]        m_q;
	logic                 full_q;
	logic                 empty;
	logic                 joins;
	logic                 push;
	logic                 room;

	assign empty = a > b;
	assign joins = cur_valid_q && ((cur_hi_q == iis_pkg::S64_MAX) || (cur_hi_q + 64'sd1 >= a));
	assign push  = cur_valid_q && ((ctl.feed && !empty && !joins) || ctl.flush);
	assign room  = m_q < CW'(MAX_INTERVALS);
	assign we    = push && room;
	assign widx  = m_q[IW-1:0];
	assign wlo   = cur_lo_q;
	assign whi   = cur_hi_q;
	assign count = m_q;
	assign full  = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			m_q         <= '0;
			full_q      <= 1'b0;
		end else if (ctl.clear) begin
			cur_valid_q <= 1'b0;
			m_q         <= '0;
			full_q      <= 1'b0;
		end else begin
			if (push) begin
				if (room) begin
					m_q <= m_q + CW'(1);
				end else begin
					full_q <= 1'b1;
				end
			end
			if (ctl.flush) begin
				cur_valid_q <= 1'b0;
			end else if (ctl.feed && !empty) begin
				if (joins) begin
					if (b > cur_hi_q) begin
						cur_hi_q <= b;
					end
				end else begin
					cur_lo_q    <= a;
					cur_hi_q    <= b;
					cur_valid_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_interval_set_core.sv =====
`default_nettype none

// Sorted set of disjoint signed 64-bit closed intervals.
// Pulse start with func and its operands while busy is low; the word is taken
// at that edge and busy stays high until the result is shown. The result
// appears on found, saturated, full_res and entry_count for exactly one cycle,
// marked by done; the receiver cannot stall it.
// The table lives in one RAM holding two banks. Every operation streams the
// current bank through a merge unit into the other bank, entry by entry (read,
// then consume), and the banks swap only if the new table fits.
// An insert also feeds its own interval into the merge unit, and a delete that
// splits an interval feeds its upper piece as well. The registered RAM read
// port is why each entry is read before it is consumed.
// After reset the table is empty and the block is ready at once.

module integer_interval_set_core #(
	parameter int MAX_INTERVALS = iis_pkg::MAX_INTERVALS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         func,
	input  wire logic signed [63:0] range_low,
	input  wire logic signed [63:0] range_high,
	input  wire logic signed [63:0] point,
	output logic                    done,
	output logic                    found,
	output logic                    saturated,
	output logic                    full_res,
	output logic [4:0]              entry_count
);

	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int IW = $clog2(MAX_INTERVALS);
	localparam int RAM_DEPTH = 2 * (2 ** IW);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_CONS, S_DRAIN, S_FLUSH, S_DONE} state_t;

	state_t               state_q;
	logic [1:0]           func_q;
	logic signed [63:0]   rlo_q;
	logic signed [63:0]   rhi_q;
	logic signed [63:0]   pt_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        count_q;
	logic                 bank_q;
	logic                 ins_done_q;
	logic                 pend2_q;
	logic                 found_q;
	logic                 sat_q;
	logic                 feed_s1;
	logic signed [63:0]   feed_lo_s1;
	logic signed [63:0]   feed_hi_s1;

	logic [127:0]         rdata;
	logic signed [63:0]   d_lo;
	logic signed [63:0]   d_hi;
	logic                 covers;
	logic [64:0]          sum_lo;
	logic [64:0]          sum_hi;
	logic signed [63:0]   add_lo;
	logic signed [63:0]   add_hi;
	logic                 ovf_lo;
	logic                 ovf_hi;

	iis_pkg::merge_ctl_t  mctl;
	logic                 m_we;
	logic [IW-1:0]        m_widx;
	logic signed [63:0]   m_wlo;
	logic signed [63:0]   m_whi;
	logic [CW-1:0]        m_count;
	logic                 m_full;
	logic                 commit;
	logic [CW-1:0]        result_count;
	logic [31:0]          count_ext;

	assign d_lo   = rdata[127:64];
	assign d_hi   = rdata[63:0];
	assign covers = !found_q && (d_lo <= pt_q) && (pt_q <= d_hi);

	assign sum_lo = {d_lo[63], d_lo} + {rlo_q[63], rlo_q};
	assign sum_hi = {d_hi[63], d_hi} + {rhi_q[63], rhi_q};
	assign ovf_lo = sum_lo[64] != sum_lo[63];
	assign ovf_hi = sum_hi[64] != sum_hi[63];
	assign add_lo = ovf_lo ? (sum_lo[64] ? iis_pkg::S64_MIN : iis_pkg::S64_MAX)
		: sum_lo[63:0];
	assign add_hi = ovf_hi ? (sum_hi[64] ? iis_pkg::S64_MIN : iis_pkg::S64_MAX)
		: sum_hi[63:0];

	assign mctl.clear = start && !busy;
	assign mctl.feed  = feed_s1;
	assign mctl.flush = state_q == S_FLUSH;

	iis_ram #(
		.WIDTH(128),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr({~bank_q, m_widx}),
		.wdata({m_wlo, m_whi}),
		.raddr({bank_q, i_q[IW-1:0]}),
		.rdata(rdata)
	);

	iis_merge #(
		.MAX_INTERVALS(MAX_INTERVALS)
	) u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mctl),
		.a     (feed_lo_s1),
		.b     (feed_hi_s1),
		.we    (m_we),
		.widx  (m_widx),
		.wlo   (m_wlo),
		.whi   (m_whi),
		.count (m_count),
		.full  (m_full)
	);

	assign commit       = (func_q != iis_pkg::FN_QUERY) && !m_full;
	assign result_count = commit ? m_count : count_q;
	assign count_ext    = 32'(result_count);

	assign busy        = state_q != S_IDLE;
	assign done        = state_q == S_DONE;
	assign found       = found_q;
	assign saturated   = sat_q;
	assign full_res    = m_full && (func_q != iis_pkg::FN_QUERY);
	assign entry_count = count_ext[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			bank_q     <= 1'b0;
			i_q        <= '0;
			ins_done_q <= 1'b0;
			pend2_q    <= 1'b0;
			found_q    <= 1'b0;
			sat_q      <= 1'b0;
			feed_s1    <= 1'b0;
		end else begin
			feed_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q     <= func;
						rlo_q      <= range_low;
						rhi_q      <= range_high;
						pt_q       <= point;
						i_q        <= '0;
						ins_done_q <= 1'b0;
						pend2_q    <= 1'b0;
						found_q    <= 1'b0;
						sat_q      <= 1'b0;
						state_q    <= S_READ;
					end
				end
				S_READ: begin
					if (i_q < count_q) begin
						state_q <= S_CONS;
					end else if (func_q == iis_pkg::FN_INSERT && !ins_done_q) begin
						feed_s1    <= 1'b1;
						feed_lo_s1 <= rlo_q;
						feed_hi_s1 <= rhi_q;
						ins_done_q <= 1'b1;
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_CONS: begin
					state_q <= S_READ;
					case (func_q)
						iis_pkg::FN_INSERT: begin
							feed_s1 <= 1'b1;
							if (!ins_done_q && d_lo >= rlo_q) begin
								feed_lo_s1 <= rlo_q;
								feed_hi_s1 <= rhi_q;
								ins_done_q <= 1'b1;
							end else begin
								feed_lo_s1 <= d_lo;
								feed_hi_s1 <= d_hi;
								i_q        <= i_q + CW'(1);
							end
						end
						iis_pkg::FN_DELETE, iis_pkg::FN_QUERY: begin
							if (pend2_q) begin
								feed_s1    <= 1'b1;
								feed_lo_s1 <= pt_q + 64'sd1;
								feed_hi_s1 <= d_hi;
								pend2_q    <= 1'b0;
								i_q        <= i_q + CW'(1);
							end else if (covers) begin
								found_q <= 1'b1;
								if (d_lo == pt_q && d_hi == pt_q) begin
									i_q <= i_q + CW'(1);
								end else if (d_lo == pt_q) begin
									feed_s1    <= 1'b1;
									feed_lo_s1 <= pt_q + 64'sd1;
									feed_hi_s1 <= d_hi;
									i_q        <= i_q + CW'(1);
								end else if (d_hi == pt_q) begin
									feed_s1    <= 1'b1;
									feed_lo_s1 <= d_lo;
									feed_hi_s1 <= pt_q - 64'sd1;
									i_q        <= i_q + CW'(1);
								end else begin
									feed_s1    <= 1'b1;
									feed_lo_s1 <= d_lo;
									feed_hi_s1 <= pt_q - 64'sd1;
									pend2_q    <= 1'b1;
								end
							end else begin
								feed_s1    <= 1'b1;
								feed_lo_s1 <= d_lo;
								feed_hi_s1 <= d_hi;
								i_q        <= i_q + CW'(1);
							end
						end
						default: begin
							feed_s1    <= 1'b1;
							feed_lo_s1 <= add_lo;
							feed_hi_s1 <= add_hi;
							sat_q      <= sat_q | ovf_lo | ovf_hi;
							i_q        <= i_q + CW'(1);
						end
					endcase
				end
				S_DRAIN: begin
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (commit) begin
						bank_q  <= ~bank_q;
						count_q <= m_count;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> i_q <= count_q)
		else $error("scan index passed the stored count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_INTERVALS))
		else $error("stored count above capacity");

	a_full_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(done && full_res) |-> (func_q == iis_pkg::FN_INSERT || func_q == iis_pkg::FN_DELETE))
		else $error("overflow flagged for an operation that cannot grow the table");

endmodule

`default_nettype wire
